@@ rtl/core/rro_pkg.sv @@
package rro_pkg;

	// corner sign pattern, bit i set means +1 for corner i
	localparam logic [3:0] EX_POS = 4'b0110;
	localparam logic [3:0] EY_POS = 4'b1100;

	// 2*pi in Q30
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	// quarter-wave sine entry in Q1.tbits, evaluated at elaboration only
	function automatic logic [63:0] quarter_sine(input logic [63:0] k, input int abits,
		input int tbits);
		logic [63:0] theta;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] r;
		logic signed [63:0] sum;
		theta = (TWO_PI_Q30 * k) >> abits;
		t2 = (theta * theta) >> 30;
		term = theta;
		sum = $signed(theta);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		r = ($unsigned(sum) + (64'd1 << (29 - tbits))) >> (30 - tbits);
		if (r > (64'd1 << tbits)) begin
			r = 64'd1 << tbits;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/rro_trig.sv @@
module rro_trig #(
	parameter int ANGLE_BITS     = 12,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ANGLE_BITS-1:0]            angle,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_v,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_v
);
	import rro_pkg::*;

	localparam int QB      = ANGLE_BITS - 2;
	localparam int QUARTER = 1 << QB;

	logic [TRIG_FRAC_BITS:0] tab [QUARTER+1];
	logic [ANGLE_BITS-1:0]   cos_ang;
	logic [QB:0]             sin_idx, cos_idx;
	logic [TRIG_FRAC_BITS:0] sin_mag_s1, cos_mag_s1;
	logic                    sin_neg_s1, cos_neg_s1;

	for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
		assign tab[k] = (TRIG_FRAC_BITS+1)'(quarter_sine(64'(k), ANGLE_BITS, TRIG_FRAC_BITS));
	end

	// cos is sin a quarter turn ahead
	assign cos_ang = angle + ANGLE_BITS'(QUARTER);

	// odd quadrants read the table mirrored
	always_comb begin
		sin_idx = angle[QB] ? ((QB+1)'(QUARTER) - {1'b0, angle[QB-1:0]})
			: {1'b0, angle[QB-1:0]};
		cos_idx = cos_ang[QB] ? ((QB+1)'(QUARTER) - {1'b0, cos_ang[QB-1:0]})
			: {1'b0, cos_ang[QB-1:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s1 <= tab[sin_idx];
			cos_mag_s1 <= tab[cos_idx];
			sin_neg_s1 <= angle[QB+1];
			cos_neg_s1 <= cos_ang[QB+1];
		end
	end

	assign sin_v = sin_neg_s1 ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
	assign cos_v = cos_neg_s1 ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});

endmodule

@@ rtl/core/rotated_rect_overlap_test_top.sv @@
// Overlap test for two rotated rectangles by the separating axis test. Each beat on the input
// carries both rectangles (top-left corner, width, height, rotation about the center in binary
// angle steps); each output beat carries one overlap bit, 1 when the shapes intersect, touching
// included. The datapath is exact: corners are kept at twice the coordinate times the trig
// scale and projections are full width, so no rounding or saturation affects the decision.
// One pair is accepted every cycle while the output side takes results. Stages: sine/cosine
// quarter-wave table read, edge products, corner sums, projection multiplies onto the edge axes
// of both rectangles, min/max per interval, interval compare. The whole pipeline holds when the
// output beat is not taken.
module rotated_rect_overlap_test_top #(
	parameter int COORD_BITS     = 16,
	parameter int ANGLE_BITS     = 12,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_left,
	input  logic signed [COORD_BITS-1:0] a_top,
	input  logic [COORD_BITS-2:0]        a_width,
	input  logic [COORD_BITS-2:0]        a_height,
	input  logic [ANGLE_BITS-1:0]        a_angle,
	input  logic signed [COORD_BITS-1:0] b_left,
	input  logic signed [COORD_BITS-1:0] b_top,
	input  logic [COORD_BITS-2:0]        b_width,
	input  logic [COORD_BITS-2:0]        b_height,
	input  logic [ANGLE_BITS-1:0]        b_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         overlap
);
	import rro_pkg::*;

	localparam int W   = COORD_BITS;
	localparam int T   = TRIG_FRAC_BITS;
	localparam int TW  = T + 2;          // trig value width
	localparam int KW  = W + 2 + T;      // scaled center width
	localparam int MW  = W + T + 2;      // edge product width
	localparam int PW  = W + T + 4;      // corner width
	localparam int PRW = PW + TW + 1;    // projection width

	// one enable for every stage: advance unless the result beat is held
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	assign en       = !vld_s6 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// stage 1: table read for both angles, geometry registered alongside
	logic signed [TW-1:0] sin_v [2];
	logic signed [TW-1:0] cos_v [2];

	rro_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(T)) u_trig_a (
		.clk(clk), .en(en), .angle(a_angle), .sin_v(sin_v[0]), .cos_v(cos_v[0])
	);
	rro_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(T)) u_trig_b (
		.clk(clk), .en(en), .angle(b_angle), .sin_v(sin_v[1]), .cos_v(cos_v[1])
	);

	logic signed [W-1:0] left_s1 [2];
	logic signed [W-1:0] top_s1  [2];
	logic [W-2:0]        w_s1    [2];
	logic [W-2:0]        h_s1    [2];

	always_ff @(posedge clk) begin
		if (en) begin
			left_s1[0] <= a_left;
			top_s1[0]  <= a_top;
			w_s1[0]    <= a_width;
			h_s1[0]    <= a_height;
			left_s1[1] <= b_left;
			top_s1[1]  <= b_top;
			w_s1[1]    <= b_width;
			h_s1[1]    <= b_height;
		end
	end

	// stage 2: doubled centers scaled to the trig format, and edge products
	logic signed [KW-1:0] kx_s2 [2], ky_s2 [2];
	logic signed [MW-1:0] wc_s2 [2], hs_s2 [2], ws_s2 [2], hc_s2 [2];
	logic signed [TW-1:0] c_s2  [2], s_s2  [2];

	for (genvar r = 0; r < 2; r++) begin : g_s2
		logic signed [W+1:0] cx, cy;
		logic signed [W-1:0] ws, hs;

		assign cx = {left_s1[r][W-1], left_s1[r], 1'b0} + $signed({3'b000, w_s1[r]});
		assign cy = {top_s1[r][W-1], top_s1[r], 1'b0} + $signed({3'b000, h_s1[r]});
		assign ws = $signed({1'b0, w_s1[r]});
		assign hs = $signed({1'b0, h_s1[r]});

		always_ff @(posedge clk) begin
			if (en) begin
				kx_s2[r] <= {cx, {T{1'b0}}};
				ky_s2[r] <= {cy, {T{1'b0}}};
				wc_s2[r] <= MW'(ws * cos_v[r]);
				hs_s2[r] <= MW'(hs * sin_v[r]);
				ws_s2[r] <= MW'(ws * sin_v[r]);
				hc_s2[r] <= MW'(hs * cos_v[r]);
				c_s2[r]  <= cos_v[r];
				s_s2[r]  <= sin_v[r];
			end
		end
	end

	// stage 3: the four corners of each rectangle
	logic signed [PW-1:0] px_s3 [2][4], py_s3 [2][4];
	logic signed [TW-1:0] c_s3  [2], s_s3 [2];

	for (genvar r = 0; r < 2; r++) begin : g_s3
		for (genvar i = 0; i < 4; i++) begin : g_corner
			logic signed [PW-1:0] ex_wc, ex_ws, ey_hs, ey_hc;

			assign ex_wc = EX_POS[i] ? PW'(wc_s2[r]) : -PW'(wc_s2[r]);
			assign ex_ws = EX_POS[i] ? PW'(ws_s2[r]) : -PW'(ws_s2[r]);
			assign ey_hs = EY_POS[i] ? PW'(hs_s2[r]) : -PW'(hs_s2[r]);
			assign ey_hc = EY_POS[i] ? PW'(hc_s2[r]) : -PW'(hc_s2[r]);

			always_ff @(posedge clk) begin
				if (en) begin
					px_s3[r][i] <= PW'(kx_s2[r]) + ex_wc - ey_hs;
					py_s3[r][i] <= PW'(ky_s2[r]) + ex_ws + ey_hc;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s3[r] <= c_s2[r];
				s_s3[r] <= s_s2[r];
			end
		end
	end

	// stage 4: every corner onto every edge axis, axes left unnormalized
	logic signed [TW-1:0]  ux [4], uy [4];
	logic signed [PRW-1:0] prj_s4 [4][2][4];

	assign ux[0] = c_s3[0];
	assign uy[0] = s_s3[0];
	assign ux[1] = -s_s3[0];
	assign uy[1] = c_s3[0];
	assign ux[2] = c_s3[1];
	assign uy[2] = s_s3[1];
	assign ux[3] = -s_s3[1];
	assign uy[3] = c_s3[1];

	for (genvar j = 0; j < 4; j++) begin : g_axis
		for (genvar r = 0; r < 2; r++) begin : g_rect
			for (genvar i = 0; i < 4; i++) begin : g_pt
				always_ff @(posedge clk) begin
					if (en) begin
						prj_s4[j][r][i] <= PRW'(px_s3[r][i] * ux[j]) + PRW'(py_s3[r][i] * uy[j]);
					end
				end
			end
		end
	end

	// stage 5: interval ends per axis and rectangle
	logic signed [PRW-1:0] lo_s5 [4][2], hi_s5 [4][2];

	for (genvar j = 0; j < 4; j++) begin : g_ext
		for (genvar r = 0; r < 2; r++) begin : g_rect
			logic signed [PRW-1:0] lo01, lo23, hi01, hi23;

			assign lo01 = (prj_s4[j][r][1] < prj_s4[j][r][0]) ? prj_s4[j][r][1] : prj_s4[j][r][0];
			assign lo23 = (prj_s4[j][r][3] < prj_s4[j][r][2]) ? prj_s4[j][r][3] : prj_s4[j][r][2];
			assign hi01 = (prj_s4[j][r][1] > prj_s4[j][r][0]) ? prj_s4[j][r][1] : prj_s4[j][r][0];
			assign hi23 = (prj_s4[j][r][3] > prj_s4[j][r][2]) ? prj_s4[j][r][3] : prj_s4[j][r][2];

			always_ff @(posedge clk) begin
				if (en) begin
					lo_s5[j][r] <= (lo23 < lo01) ? lo23 : lo01;
					hi_s5[j][r] <= (hi23 > hi01) ? hi23 : hi01;
				end
			end
		end
	end

	// stage 6: a gap on any axis separates the shapes; equal ends still touch
	logic [3:0] gap;
	logic       overlap_s6;

	for (genvar j = 0; j < 4; j++) begin : g_gap
		assign gap[j] = (hi_s5[j][0] < lo_s5[j][1]) || (hi_s5[j][1] < lo_s5[j][0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			overlap_s6 <= ~|gap;
		end
	end

	assign out_valid = vld_s6;
	assign overlap   = overlap_s6;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted beat did not enter stage 1");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5}))
		else $error("pipeline valid bits moved during a stall");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s5 |=> vld_s6)
		else $error("beat lost between stage 5 and stage 6");

endmodule

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rro_pkg::*;

	localparam int QUARTER = 1024;
	localparam longint ONE_Q = 64'sd16384;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic signed [15:0] a_left;
		logic signed [15:0] a_top;
		logic [14:0] a_width;
		logic [14:0] a_height;
		logic [11:0] a_angle;
		logic signed [15:0] b_left;
		logic signed [15:0] b_top;
		logic [14:0] b_width;
		logic [14:0] b_height;
		logic [11:0] b_angle;
	} rect_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic overlap;
	rect_pair_t drv = '0;

	// quarter-wave sine table, Q1.14
	longint sine_rom [0:QUARTER];
	bit overlap_q [$];
	int mismatches = 0;
	int pairs_sent = 0;
	int results_seen = 0;
	int hits_seen = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	always #6 clk = ~clk;

	rotated_rect_overlap_test_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_left(drv.a_left), .a_top(drv.a_top), .a_width(drv.a_width),
		.a_height(drv.a_height), .a_angle(drv.a_angle),
		.b_left(drv.b_left), .b_top(drv.b_top), .b_width(drv.b_width),
		.b_height(drv.b_height), .b_angle(drv.b_angle),
		.out_valid(out_valid), .out_ready(out_ready), .overlap(overlap)
	);

	// taylor series for sin on the first quadrant, rounded half up to 14 bits
	function automatic longint series_sine(input longint unsigned k);
		longint unsigned theta, t2, term, r;
		longint sum;
		theta = (64'd6746518852 * k) >> 12;
		t2 = (theta * theta) >> 30;
		term = theta;
		sum = longint'(theta);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
			sum = n[0] ? sum - longint'(term) : sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		r = (longint'(sum) + (64'd1 << 15)) >> 16;
		if (r > 64'd16384) r = 64'd16384;
		return longint'(r);
	endfunction

	function automatic longint sine_at(input logic [11:0] ang);
		logic [9:0] r;
		longint v;
		r = ang[9:0];
		v = ang[10] ? sine_rom[QUARTER - r] : sine_rom[r];
		return ang[11] ? -v : v;
	endfunction

	// corners held at 2 * 2^14 times their coordinate
	task automatic build_corners(input logic signed [15:0] left, input logic signed [15:0] top,
		input logic [14:0] w, input logic [14:0] h, input longint c, input longint s,
		output longint px [4], output longint py [4]);
		longint kx, ky, sx, sy, wl, hl;
		wl = w;
		hl = h;
		kx = (2 * longint'(left) + wl) * ONE_Q;
		ky = (2 * longint'(top) + hl) * ONE_Q;
		for (int i = 0; i < 4; i++) begin
			sx = EX_POS[i] ? 1 : -1;
			sy = EY_POS[i] ? 1 : -1;
			px[i] = kx + sx * wl * c - sy * hl * s;
			py[i] = ky + sx * wl * s + sy * hl * c;
		end
	endtask

	task automatic span_on_axis(input longint ux, input longint uy, input longint px [4],
		input longint py [4], output longint lo, output longint hi);
		longint p;
		for (int i = 0; i < 4; i++) begin
			p = px[i] * ux + py[i] * uy;
			if (i == 0 || p < lo) lo = p;
			if (i == 0 || p > hi) hi = p;
		end
	endtask

	// separating axis decision over both rectangles' edge directions
	task automatic predict_overlap(input rect_pair_t p, output bit hit);
		longint sa, ca, sb, cb, lo1, hi1, lo2, hi2;
		longint ax [4], ay [4], bx [4], by [4], ux [4], uy [4];
		sa = sine_at(p.a_angle);
		ca = sine_at(p.a_angle + 12'd1024);
		sb = sine_at(p.b_angle);
		cb = sine_at(p.b_angle + 12'd1024);
		build_corners(p.a_left, p.a_top, p.a_width, p.a_height, ca, sa, ax, ay);
		build_corners(p.b_left, p.b_top, p.b_width, p.b_height, cb, sb, bx, by);
		ux = '{ca, -sa, cb, -sb};
		uy = '{sa, ca, sb, cb};
		hit = 1'b1;
		for (int i = 0; i < 4; i++) begin
			span_on_axis(ux[i], uy[i], ax, ay, lo1, hi1);
			span_on_axis(ux[i], uy[i], bx, by, lo2, hi2);
			if (hi1 < lo2 || hi2 < lo1) hit = 1'b0;
		end
	endtask

	task automatic report(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// input and output values are stable at the falling edge and are the ones
	// that move at the next rising edge
	always @(negedge clk) begin
		bit want;
		if (arst_n && in_valid && in_ready) begin
			predict_overlap(drv, want);
			overlap_q.push_back(want);
			pairs_sent++;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (overlap_q.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				want = overlap_q.pop_front();
				hits_seen += want;
				if (overlap !== want)
					report($sformatf("overlap got %b want %b", overlap, want));
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 9) < 3)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// one beat, held until taken, then an optional gap
	task automatic send_pair(input rect_pair_t p);
		bit taken;
		int gap;
		drv <= p;
		in_valid <= 1'b1;
		forever begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
			if (taken) break;
		end
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic rect_pair_t aligned(input int al, input int at, input int aw, input int ah,
		input int bl, input int bt, input int bw, input int bh);
		rect_pair_t p;
		p = '0;
		p.a_left = 16'(al); p.a_top = 16'(at); p.a_width = 15'(aw); p.a_height = 15'(ah);
		p.b_left = 16'(bl); p.b_top = 16'(bt); p.b_width = 15'(bw); p.b_height = 15'(bh);
		return p;
	endfunction

	// extremes of every field
	task automatic test_extremes();
		rect_pair_t p;
		send_pair('0);
		send_pair('1);
		p = aligned(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
		send_pair(p);
		p.a_angle = 12'd4095; p.b_angle = 12'd2048;
		send_pair(p);
		p = aligned(32767, 32767, 0, 0, -32768, -32768, 32767, 32767);
		send_pair(p);
		p = aligned(-32768, 32767, 32767, 0, 32767, -32768, 0, 32767);
		p.a_angle = 12'd1024; p.b_angle = 12'd3072;
		send_pair(p);
	endtask

	// equal interval ends, one step apart, and rotated corner contact
	task automatic test_touching();
		rect_pair_t p;
		send_pair(aligned(0, 0, 16, 16, 16, 0, 16, 16));
		send_pair(aligned(0, 0, 16, 16, 17, 0, 16, 16));
		send_pair(aligned(0, 0, 16, 16, 0, 16, 16, 16));
		send_pair(aligned(0, 0, 16, 16, 0, -17, 16, 16));
		send_pair(aligned(0, 0, 16, 16, 16, 16, 16, 16));
		p = aligned(0, 0, 64, 64, 70, 0, 64, 64);
		p.b_angle = 12'd512;
		send_pair(p);
		p.a_angle = 12'd2560;
		send_pair(p);
	endtask

	// segments and points, axes from the angle alone
	task automatic test_degenerate();
		rect_pair_t p;
		send_pair(aligned(10, 10, 0, 0, 10, 10, 0, 0));
		send_pair(aligned(10, 10, 0, 0, 11, 10, 0, 0));
		p = aligned(0, 0, 100, 0, 50, -50, 0, 100);
		p.a_angle = 12'd341;
		send_pair(p);
		p = aligned(0, 0, 0, 100, 40, 0, 0, 0);
		p.a_angle = 12'd1024; p.b_angle = 12'd700;
		send_pair(p);
	endtask

	// the first three quadrants and angles at or next to their edges
	task automatic test_angles();
		rect_pair_t p;
		logic [11:0] angs [6] = '{12'd0, 12'd1, 12'd1023, 12'd1024, 12'd2049, 12'd3071};
		for (int i = 0; i < 6; i++) begin
			p = aligned(0, 0, 160, 40, 130, 60, 80, 80);
			p.a_angle = angs[i];
			p.b_angle = angs[5 - i];
			send_pair(p);
		end
	endtask

	function automatic rect_pair_t random_pair();
		rect_pair_t p;
		int r;
		p.a_angle = 12'($urandom);
		p.b_angle = 12'($urandom);
		r = $urandom_range(0, 9);
		if (r == 0) begin
			// anything the fields allow
			p.a_left = 16'($urandom); p.a_top = 16'($urandom); p.a_width = 15'($urandom);
			p.a_height = 15'($urandom); p.b_left = 16'($urandom); p.b_top = 16'($urandom);
			p.b_width = 15'($urandom); p.b_height = 15'($urandom);
		end else begin
			// neighbors, so both answers come up often
			p.a_width = (r < 3) ? 15'($urandom) : 15'($urandom_range(0, 2000));
			p.a_height = (r < 3) ? 15'($urandom) : 15'($urandom_range(0, 2000));
			p.b_width = 15'($urandom_range(0, 2000));
			p.b_height = (r == 9) ? 15'd0 : 15'($urandom_range(0, 2000));
			p.a_left = 16'($urandom);
			p.a_top = 16'($urandom);
			p.b_left = p.a_left + 16'($signed($urandom_range(0, 6000)) - 3000);
			p.b_top = p.a_top + 16'($signed($urandom_range(0, 6000)) - 3000);
		end
		return p;
	endfunction

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			// stretches with no idling on either side
			calm = (i % 150) >= 120;
			send_pair(random_pair());
		end
		calm = 1'b0;
	endtask

	initial begin
		int waited;
		for (int k = 0; k <= QUARTER; k++) sine_rom[k] = series_sine(k);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_touching();
		test_degenerate();
		test_angles();
		test_random(750);
		in_valid <= 1'b0;
		waited = 0;
		while (overlap_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
		$display("%0d rectangle pairs checked, %0d overlapping, %0d separate",
			results_seen, hits_seen, results_seen - hits_seen);
		$display("covered extremes, touching edges, degenerate shapes, all quadrants");
		if (mismatches == 0 && overlap_q.size() == 0 && results_seen == pairs_sent) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
